FILE: sv/ppdf_pkg.sv
// Shared types and constants of the PTP path delay filter.
// Used by the channel interfaces, the delay datapath, the top level and the checker.
package ppdf_pkg;

  localparam int TS_W      = 63;
  localparam int WORD_W    = 64;
  localparam int DELAY_W   = 21;
  localparam int WIN_W     = 20;
  localparam int RETRY_W   = 8;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [WIN_W-1:0]   ABS_WINDOW_RST    = 20'd1000000;
  localparam logic [WIN_W-1:0]   JITTER_WINDOW_RST = 20'd50;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST   = 8'd10;

  localparam logic [1:0] REG_ABS_WINDOW    = 2'd0;
  localparam logic [1:0] REG_JITTER_WINDOW = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd2;

  localparam logic OP_E2E  = 1'b0;
  localparam logic OP_PEER = 1'b1;

  typedef enum logic [2:0] {
    STAT_ACCEPT   = 3'd0,
    STAT_NOT_SEL  = 3'd1,
    STAT_NEGATIVE = 3'd2,
    STAT_WINDOW   = 3'd3,
    STAT_JITTER   = 3'd4,
    STAT_CLEARED  = 3'd5
  } status_e;

  typedef struct packed {
    logic              opcode;
    logic              clock_selected;
    logic [TS_W-1:0]   req_send_ns;
    logic [TS_W-1:0]   req_recv_ns;
    logic [TS_W-1:0]   resp_send_ns;
    logic [TS_W-1:0]   resp_recv_ns;
    logic [WORD_W-1:0] forward_delay;
    logic [WORD_W-1:0] applied_offset;
    logic [WORD_W-1:0] correction_scaled;
  } in_item_t;

  typedef struct packed {
    logic [DELAY_W-1:0] mean_delay;
    status_e            status;
  } out_item_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    status_e            status;
  } calc_res_t;

endpackage

FILE: sv/ppdf_if.sv
// Valid/ready channel interfaces for the input samples and the filter results.
// Depends on ppdf_pkg for the payload types.
interface ppdf_in_if;
  logic               valid;
  logic               ready;
  ppdf_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppdf_out_if;
  logic                valid;
  logic                ready;
  ppdf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/ppdf_delay_calc.sv
// Five-stage datapath that forms the one-way delay from the timestamps of one sample
// and classifies it against the sign rule and the absolute window. Depends on ppdf_pkg.
module ppdf_delay_calc (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  ppdf_pkg::in_item_t              item_i,
  input  logic [ppdf_pkg::WIN_W-1:0]      abs_window_i,
  output logic                            done_o,
  output ppdf_pkg::calc_res_t             res_o
);

  logic [4:0]  vld_q;
  logic [3:0]  op_q;
  logic [63:0] req_diff_q;
  logic [65:0] sec_q;
  logic [63:0] corr_q;
  logic [63:0] corr2_q;
  logic [67:0] sum2_q;
  logic [67:0] acc_q;
  logic        neg_q;
  logic [66:0] mag_q;

  logic [63:0] req_diff_d;
  logic [63:0] resp_diff_d;
  logic [65:0] e2e_d;
  logic [65:0] sec_d;
  logic [67:0] mag_full;
  logic [65:0] half;
  logic        win_fail;
  logic [20:0] half_low;

  assign req_diff_d  = {1'b0, item_i.req_recv_ns} - {1'b0, item_i.req_send_ns};
  assign resp_diff_d = {1'b0, item_i.resp_recv_ns} - {1'b0, item_i.resp_send_ns};
  assign e2e_d = {{2{item_i.forward_delay[63]}}, item_i.forward_delay}
               - {{2{item_i.applied_offset[63]}}, item_i.applied_offset};
  assign sec_d = (item_i.opcode == ppdf_pkg::OP_PEER) ?
                 {{2{resp_diff_d[63]}}, resp_diff_d} : e2e_d;

  assign mag_full = acc_q[67] ? (~acc_q + 68'd1) : acc_q;
  assign half     = mag_q[66:1];
  assign half_low = half[20:0];
  assign win_fail = (half[65:20] != 46'd0) || (half[19:0] > abs_window_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= {op_q[2:0], item_i.opcode};
    req_diff_q <= req_diff_d;
    sec_q      <= sec_d;
    corr_q     <= {{16{item_i.correction_scaled[63]}}, item_i.correction_scaled[63:16]};
    corr2_q    <= corr_q;
    sum2_q     <= {{4{req_diff_q[63]}}, req_diff_q} + {{2{sec_q[65]}}, sec_q};
    acc_q      <= sum2_q - {{4{corr2_q[63]}}, corr2_q};
    neg_q      <= acc_q[67];
    mag_q      <= mag_full[66:0];
    if (op_q[3] == ppdf_pkg::OP_E2E && neg_q && half != 66'd0) begin
      res_o.status <= ppdf_pkg::STAT_NEGATIVE;
      res_o.delay  <= '0;
    end else if (win_fail) begin
      res_o.status <= ppdf_pkg::STAT_WINDOW;
      res_o.delay  <= '0;
    end else begin
      res_o.status <= ppdf_pkg::STAT_ACCEPT;
      res_o.delay  <= neg_q ? (~half_low + 21'd1) : half_low;
    end
  end

  assign done_o = vld_q[4];

endmodule

FILE: sv/ppdf_divider.sv
// Radix-2 restoring divider for a signed dividend by a small unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle. Stand-alone.
module ppdf_divider #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  div_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic                  neg_q;
  logic [DIVIDEND_W-1:0] quot_q;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    trial;
  logic                  ge;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign trial   = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIVIDEND_W-1];
      quo_q <= dividend_i[DIVIDEND_W-1] ? (~dividend_i + DIVIDEND_W'(1)) : dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q && cnt_q != '0) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
      rem_q <= ge ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
    if (busy_q && cnt_q == '0) begin
      quot_q <= neg_q ? (~quo_q + DIVIDEND_W'(1)) : quo_q;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

FILE: sv/ptp_path_delay_filter.sv
// Top level of the PTP mean path delay filter: APB registers, control sequencer,
// delay ring memory. Depends on ppdf_pkg, ppdf_if, ppdf_delay_calc and ppdf_divider.
//
// The block takes one delay sample at a time and returns exactly one result per sample.
// An end-to-end sample from an unselected master skips the delay datapath, and a sample
// rejected by the sign or window check is judged by the five-stage delay datapath. Once
// the ring is full, an accepted delay first passes the jitter check, and a jitter hit
// rejects the sample. The jitter check compares against the last mean, which is held in
// a register. For an accepted sample the serial divider forms the new mean from the ring
// sum of SUM_W bits, where SUM_W = 21 + clog2(RING_DEPTH), at the default depth of 8.
// A result waits in the done state while the previous one is still held on a stalled
// output. The delay ring lives in a single-port memory read before its write-back, and
// needs no clearing after reset or after a filter clear.
module ptp_path_delay_filter #(
  parameter int RING_DEPTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ppdf_in_if.sink                            in_i,
  ppdf_out_if.source                         out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ppdf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ppdf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ppdf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int DELAY_W = ppdf_pkg::DELAY_W;
  localparam int SUM_W   = DELAY_W + $clog2(RING_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_JITTER,
    ST_UPDATE,
    ST_MEAN,
    ST_DONE
  } state_e;

  state_e                             state_q;
  ppdf_pkg::in_item_t                 item_q;
  logic [DELAY_W-1:0]                 delay_q;
  logic [DELAY_W-1:0]                 res_mean_q;
  logic [DELAY_W-1:0]                 mean_q;
  ppdf_pkg::status_e                  res_status_q;
  logic                               out_valid_q;
  ppdf_pkg::out_item_t                out_data_q;
  logic [CNT_W-1:0]                   fill_q;
  logic [PTR_W-1:0]                   wp_q;
  logic [ppdf_pkg::RETRY_W-1:0]       retry_q;
  logic [SUM_W-1:0]                   sum_q;
  logic [ppdf_pkg::WIN_W-1:0]         abs_window_q;
  logic [ppdf_pkg::WIN_W-1:0]         jitter_window_q;
  logic [ppdf_pkg::RETRY_W-1:0]       retry_limit_q;
  logic                               calc_start_q;
  logic                               div_start_q;
  logic [SUM_W-1:0]                   div_dividend_q;
  logic [CNT_W-1:0]                   div_divisor_q;

  logic [DELAY_W-1:0]                 ring_mem [RING_DEPTH];
  logic [DELAY_W-1:0]                 ram_rd_q;
  logic                               ram_re;
  logic                               ram_we;

  logic                               calc_done;
  ppdf_pkg::calc_res_t                calc_res;
  logic                               div_done;
  logic [SUM_W-1:0]                   div_quot;

  logic                               cfg_write;
  logic [1:0]                         reg_idx;
  logic                               ring_full;
  logic [PTR_W-1:0]                   wp_next;
  logic [CNT_W-1:0]                   fill_inc;
  logic [SUM_W-1:0]                   sum_upd;
  logic [ppdf_pkg::RETRY_W-1:0]       retry_inc;
  logic signed [DELAY_W+1:0]          mean_ext;
  logic signed [DELAY_W+1:0]          jit_hi;
  logic signed [DELAY_W+1:0]          jit_lo;
  logic signed [DELAY_W+1:0]          delay_ext;
  logic                               jitter_hit;

  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_comb begin
    case (reg_idx)
      ppdf_pkg::REG_ABS_WINDOW:    prdata = {12'd0, abs_window_q};
      ppdf_pkg::REG_JITTER_WINDOW: prdata = {12'd0, jitter_window_q};
      ppdf_pkg::REG_RETRY_LIMIT:   prdata = {24'd0, retry_limit_q};
      default:                     prdata = '0;
    endcase
  end

  assign ring_full = (fill_q == CNT_W'(RING_DEPTH));
  assign wp_next   = (wp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
  assign fill_inc  = ring_full ? fill_q : fill_q + CNT_W'(1);
  assign sum_upd   = sum_q
                   - (ring_full ? {{(SUM_W-DELAY_W){ram_rd_q[DELAY_W-1]}}, ram_rd_q} : '0)
                   + {{(SUM_W-DELAY_W){delay_q[DELAY_W-1]}}, delay_q};
  assign retry_inc = retry_q + ppdf_pkg::RETRY_W'(1);

  assign mean_ext   = {{2{mean_q[DELAY_W-1]}}, mean_q};
  assign delay_ext  = {{2{delay_q[DELAY_W-1]}}, delay_q};
  assign jit_hi     = mean_ext + {3'd0, jitter_window_q};
  assign jit_lo     = mean_ext - {3'd0, jitter_window_q};
  assign jitter_hit = (delay_ext > jit_hi) || (delay_ext < jit_lo);

  assign ram_re = (state_q == ST_CALC) && calc_done;
  assign ram_we = (state_q == ST_UPDATE);

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ring_mem[wp_q] <= delay_q;
    end
    if (ram_re) begin
      ram_rd_q <= ring_mem[wp_q];
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      item_q          <= '0;
      delay_q         <= '0;
      res_mean_q      <= '0;
      mean_q          <= '0;
      res_status_q    <= ppdf_pkg::STAT_ACCEPT;
      out_valid_q     <= 1'b0;
      out_data_q      <= '0;
      fill_q          <= '0;
      wp_q            <= '0;
      retry_q         <= '0;
      sum_q           <= '0;
      abs_window_q    <= ppdf_pkg::ABS_WINDOW_RST;
      jitter_window_q <= ppdf_pkg::JITTER_WINDOW_RST;
      retry_limit_q   <= ppdf_pkg::RETRY_LIMIT_RST;
      calc_start_q    <= 1'b0;
      div_start_q     <= 1'b0;
      div_dividend_q  <= '0;
      div_divisor_q   <= '0;
    end else begin
      calc_start_q <= (state_q == ST_IDLE) && in_i.valid &&
                      !(in_i.data.opcode == ppdf_pkg::OP_E2E && !in_i.data.clock_selected);
      div_start_q  <= (state_q == ST_UPDATE);
      if (cfg_write) begin
        case (reg_idx)
          ppdf_pkg::REG_ABS_WINDOW:    abs_window_q    <= pwdata[ppdf_pkg::WIN_W-1:0];
          ppdf_pkg::REG_JITTER_WINDOW: jitter_window_q <= pwdata[ppdf_pkg::WIN_W-1:0];
          ppdf_pkg::REG_RETRY_LIMIT:   retry_limit_q   <= pwdata[ppdf_pkg::RETRY_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_o.ready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            item_q <= in_i.data;
            if (in_i.data.opcode == ppdf_pkg::OP_E2E && !in_i.data.clock_selected) begin
              res_status_q <= ppdf_pkg::STAT_NOT_SEL;
              res_mean_q   <= '0;
              state_q      <= ST_DONE;
            end else begin
              state_q      <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          if (calc_done) begin
            if (calc_res.status != ppdf_pkg::STAT_ACCEPT) begin
              res_status_q <= calc_res.status;
              res_mean_q   <= '0;
              state_q      <= ST_DONE;
            end else begin
              delay_q <= calc_res.delay;
              if (ring_full) begin
                state_q <= ST_JITTER;
              end else begin
                state_q <= ST_UPDATE;
              end
            end
          end
        end
        ST_JITTER: begin
          if (jitter_hit) begin
            res_mean_q <= '0;
            state_q    <= ST_DONE;
            if (retry_inc >= retry_limit_q) begin
              fill_q       <= '0;
              wp_q         <= '0;
              retry_q      <= '0;
              sum_q        <= '0;
              res_status_q <= ppdf_pkg::STAT_CLEARED;
            end else begin
              retry_q      <= retry_inc;
              res_status_q <= ppdf_pkg::STAT_JITTER;
            end
          end else begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          sum_q          <= sum_upd;
          fill_q         <= fill_inc;
          wp_q           <= wp_next;
          retry_q        <= '0;
          div_dividend_q <= sum_upd;
          div_divisor_q  <= fill_inc;
          state_q        <= ST_MEAN;
        end
        ST_MEAN: begin
          if (div_done) begin
            res_mean_q   <= div_quot[DELAY_W-1:0];
            mean_q       <= div_quot[DELAY_W-1:0];
            res_status_q <= ppdf_pkg::STAT_ACCEPT;
            state_q      <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q           <= 1'b1;
            out_data_q.mean_delay <= res_mean_q;
            out_data_q.status     <= res_status_q;
            state_q               <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  ppdf_delay_calc u_delay_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (calc_start_q),
    .item_i       (item_q),
    .abs_window_i (abs_window_q),
    .done_o       (calc_done),
    .res_o        (calc_res)
  );

  ppdf_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dividend_q),
    .divisor_i  (div_divisor_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

endmodule

FILE: sv/ppdf_checker.sv
// Port-level checker for the PTP path delay filter and its bind to the top level.
// Depends on ppdf_pkg and ptp_path_delay_filter.
module ppdf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [ppdf_pkg::DELAY_W-1:0]  mean_delay_i,
  input logic [2:0]                    status_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(mean_delay_i) && $stable(status_i))
    else $error("result changed or dropped while stalled");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != 3'(ppdf_pkg::STAT_ACCEPT) |-> mean_delay_i == '0)
    else $error("rejected sample carries a nonzero mean");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("new sample taken while one is in progress");

endmodule

bind ptp_path_delay_filter ppdf_checker u_ppdf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .mean_delay_i (out_o.data.mean_delay),
  .status_i     (out_o.data.status)
);
